>>> rtl/rbsr_pkg.sv
// shared request codes and control structs for the ring buffer with shadow read
package rbsr_pkg;

    // request codes on req_type
    typedef enum logic [2:0] {
        REQ_PUSH     = 3'd0,
        REQ_GET      = 3'd1,
        REQ_COMMIT   = 3'd2,
        REQ_ROLLBACK = 3'd3,
        REQ_CLEAR    = 3'd4
    } req_t;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 7;

    // status of one handled item, from the controller to the result stages
    typedef struct packed {
        logic               accepted;
        logic               rd_used;
        logic [COUNT_W-1:0] pending_count;
        logic               full_flag;
    } step_res_t;

endpackage

>>> rtl/rbsr_in_if.sv
// request channel: valid, ready and the request item fields
interface rbsr_in_if;
    import rbsr_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic [DATA_W-1:0] push_data;
    logic              commit_after_read;

    modport source (
        output valid, req_type, push_data, commit_after_read,
        input  ready
    );

    modport sink (
        input  valid, req_type, push_data, commit_after_read,
        output ready
    );
endinterface

>>> rtl/rbsr_out_if.sv
// result channel: valid, ready and the result item fields
interface rbsr_out_if;
    import rbsr_pkg::*;

    logic               valid;
    logic               ready;
    logic               accepted;
    logic [DATA_W-1:0]  read_data;
    logic [COUNT_W-1:0] pending_count;
    logic               full_flag;

    modport source (
        output valid, accepted, read_data, pending_count, full_flag,
        input  ready
    );

    modport sink (
        input  valid, accepted, read_data, pending_count, full_flag,
        output ready
    );
endinterface

>>> rtl/rbsr_mem.sv
// record store: one write port, one read port, registered read data
module rbsr_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/rbsr_ctrl.sv
// pointer and length state, request decode and memory port control
module rbsr_ctrl
    import rbsr_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [2:0]               req_type,
    input  logic                     commit_after_read,
    output logic                     mem_wr_en,
    output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
    output logic                     mem_rd_en,
    output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
    output step_res_t                res
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned LEN_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(DEPTH);

    logic [PTR_W-1:0] wr_ptr_reg,  wr_ptr_next;
    logic [PTR_W-1:0] cm_ptr_reg,  cm_ptr_next;
    logic [LEN_W-1:0] cm_len_reg,  cm_len_next;
    logic [PTR_W-1:0] sh_ptr_reg,  sh_ptr_next;
    logic [LEN_W-1:0] sh_len_reg,  sh_len_next;
    logic             full_reg,    full_next;
    logic             acc;
    logic             wr_en;
    logic             rd_en;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == LAST_SLOT) ? '0 : p + 1'b1;
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        cm_ptr_next = cm_ptr_reg;
        cm_len_next = cm_len_reg;
        sh_ptr_next = sh_ptr_reg;
        sh_len_next = sh_len_reg;
        full_next   = full_reg;
        acc         = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        unique case (req_t'(req_type))
            REQ_PUSH:
            begin
                if (!full_reg)
                begin
                    if (next_slot(wr_ptr_reg) == cm_ptr_reg)
                    begin
                        full_next = 1'b1;
                    end
                    wr_en       = 1'b1;
                    wr_ptr_next = next_slot(wr_ptr_reg);
                    if (cm_len_reg < MAX_LEN)
                    begin
                        cm_len_next = cm_len_reg + 1'b1;
                    end
                    if (sh_len_reg < MAX_LEN)
                    begin
                        sh_len_next = sh_len_reg + 1'b1;
                    end
                    acc = 1'b1;
                end
            end
            REQ_GET:
            begin
                if (sh_len_reg != '0)
                begin
                    rd_en       = 1'b1;
                    sh_ptr_next = next_slot(sh_ptr_reg);
                    sh_len_next = sh_len_reg - 1'b1;
                    // commit against the advanced shadow side
                    if (commit_after_read && ((cm_ptr_reg != sh_ptr_next) || full_reg))
                    begin
                        cm_ptr_next = sh_ptr_next;
                        cm_len_next = sh_len_next;
                        full_next   = 1'b0;
                    end
                    acc = 1'b1;
                end
            end
            REQ_COMMIT:
            begin
                if ((cm_ptr_reg != sh_ptr_reg) || full_reg)
                begin
                    cm_ptr_next = sh_ptr_reg;
                    cm_len_next = sh_len_reg;
                    full_next   = 1'b0;
                end
                acc = 1'b1;
            end
            REQ_ROLLBACK:
            begin
                sh_ptr_next = cm_ptr_reg;
                sh_len_next = cm_len_reg;
                acc         = 1'b1;
            end
            REQ_CLEAR:
            begin
                wr_ptr_next = '0;
                cm_ptr_next = '0;
                cm_len_next = '0;
                sh_ptr_next = '0;
                sh_len_next = '0;
                full_next   = 1'b0;
                acc         = 1'b1;
            end
            default:
            begin
                acc = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            cm_ptr_reg <= '0;
            cm_len_reg <= '0;
            sh_ptr_reg <= '0;
            sh_len_reg <= '0;
            full_reg   <= 1'b0;
        end
        else if (step)
        begin
            wr_ptr_reg <= wr_ptr_next;
            cm_ptr_reg <= cm_ptr_next;
            cm_len_reg <= cm_len_next;
            sh_ptr_reg <= sh_ptr_next;
            sh_len_reg <= sh_len_next;
            full_reg   <= full_next;
        end
    end

    assign mem_wr_en   = step && wr_en;
    assign mem_wr_addr = wr_ptr_reg;
    assign mem_rd_en   = step && rd_en;
    assign mem_rd_addr = sh_ptr_reg;

    assign res.accepted      = acc;
    assign res.rd_used       = rd_en;
    assign res.pending_count = COUNT_W'(sh_len_next);
    assign res.full_flag     = full_next;

endmodule

>>> rtl/ring_buffer_with_shadow_read.sv
// top level of the ring buffer with shadow read pointer
//
// usage
//   in_ch carries one request item: push, get, commit, roll back or clear.
//   out_ch returns exactly one result item per request item, in order.
//   an item moves on a channel at a rising edge with valid and ready high.
// pipeline and throughput
//   a result is offered once its request has passed the middle stage,
//   written together with the controller update and the record store
//   read, and then the result register. one request item per cycle is
//   taken in steady state while out_ch does not stall. the record store
//   has a single read port, whose data is registered and goes on to the result register.
// reset
//   rst_n clears pointers, lengths, the full flag and the valid bits of both result stages.
//   record store contents are not cleared; entries read back only after
//   a push has written them.
// receiver stall
//   when out_ch stalls the result register holds, the middle stage holds
//   one more item, and then in_ch.ready drops until the result is taken.
module ring_buffer_with_shadow_read
    import rbsr_pkg::*;
#(
    parameter int unsigned DEPTH        = 64,
    parameter int unsigned RECORD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    rbsr_in_if.sink     in_ch,
    rbsr_out_if.source  out_ch
);

    localparam int unsigned PTR_W = $clog2(DEPTH);

    // controller to memory
    logic                    mem_wr_en;
    logic [PTR_W-1:0]        mem_wr_addr;
    logic                    mem_rd_en;
    logic [PTR_W-1:0]        mem_rd_addr;
    logic [RECORD_WIDTH-1:0] mem_wr_data;
    logic [RECORD_WIDTH-1:0] mem_rd_data;
    logic [DATA_W-1:0]       rd_data_low;

    step_res_t ctrl_res;

    // middle stage: status waits here while the store read completes
    logic      s1_valid_reg;
    step_res_t s1_res_reg;

    // result register
    logic               out_valid_reg;
    logic               out_acc_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_full_reg;

    logic in_take;
    logic advance;

    // the middle stage moves on when the result register is free or drains
    assign advance = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_take = in_ch.valid && in_ch.ready;

    // record width adaptation: records hold RECORD_WIDTH bits, ports hold 32
    generate
        if (RECORD_WIDTH == DATA_W)
        begin : gen_eq
            assign mem_wr_data = in_ch.push_data;
            assign rd_data_low = mem_rd_data;
        end
        else if (RECORD_WIDTH > DATA_W)
        begin : gen_wide
            assign mem_wr_data = {{(RECORD_WIDTH - DATA_W){1'b0}}, in_ch.push_data};
            assign rd_data_low = mem_rd_data[DATA_W-1:0];
        end
        else
        begin : gen_narrow
            assign mem_wr_data = in_ch.push_data[RECORD_WIDTH-1:0];
            assign rd_data_low = {{(DATA_W - RECORD_WIDTH){1'b0}}, mem_rd_data};
        end
    endgenerate

    rbsr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (in_take),
        .req_type          (in_ch.req_type),
        .commit_after_read (in_ch.commit_after_read),
        .mem_wr_en         (mem_wr_en),
        .mem_wr_addr       (mem_wr_addr),
        .mem_rd_en         (mem_rd_en),
        .mem_rd_addr       (mem_rd_addr),
        .res               (ctrl_res)
    );

    rbsr_mem #(
        .DEPTH (DEPTH),
        .WIDTH (RECORD_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // middle stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // middle stage payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_res_reg <= ctrl_res;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload; store data is used only by a successful get
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_acc_reg   <= s1_res_reg.accepted;
            out_data_reg  <= s1_res_reg.rd_used ? rd_data_low : '0;
            out_count_reg <= s1_res_reg.pending_count;
            out_full_reg  <= s1_res_reg.full_flag;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.accepted      = out_acc_reg;
    assign out_ch.read_data     = out_data_reg;
    assign out_ch.pending_count = out_count_reg;
    assign out_ch.full_flag     = out_full_reg;

    // a stalled result register keeps the middle stage occupied
    a_s1_holds_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ch.ready |=> s1_valid_reg
    ) else $error("middle stage dropped an item during an output stall");

    // a store read is only issued for an item entering the middle stage
    a_read_with_take: assert property (
        @(posedge clk) disable iff (!rst_n)
        mem_rd_en |-> in_take && ctrl_res.accepted
    ) else $error("store read issued without an accepted get");

    // the status of a successful get marks the store data as used
    a_get_marks_read: assert property (
        @(posedge clk) disable iff (!rst_n)
        mem_rd_en |=> s1_valid_reg && s1_res_reg.rd_used
    ) else $error("get status lost its store read mark");

endmodule

>>> verif/ring_buffer_with_shadow_read_test.sv
// self-checking testbench for the ring buffer with shadow read pointer
module ring_buffer_with_shadow_read_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rbsr_pkg::*;

    localparam int unsigned DEPTH       = 64;
    localparam int unsigned RECORD_W    = 32;
    localparam int unsigned RANDOM_ITEMS = 750;
    // idling stops once this many known-code items, directed ones included, are queued
    localparam int unsigned QUIET_FROM  = 650;
    // settle cycles after the last result, well past the block's latency
    localparam int unsigned SETTLE_CYC  = 8;

    // one request item as driven on the request channel
    typedef struct {
        logic [2:0]        req_type;
        logic [DATA_W-1:0] push_data;
        logic              commit_after_read;
    } request_t;

    // one result item as seen on the result channel
    typedef struct {
        logic               accepted;
        logic [DATA_W-1:0]  read_data;
        logic [COUNT_W-1:0] pending_count;
        logic               full_flag;
    } outcome_t;

    logic clk;
    logic rst_n;

    rbsr_in_if  req_ch ();
    rbsr_out_if res_ch ();

    ring_buffer_with_shadow_read #(
        .DEPTH        (DEPTH),
        .RECORD_WIDTH (RECORD_W)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch),
        .out_ch (res_ch)
    );

    // requests waiting to be driven, and outcomes waiting to be seen
    request_t request_queue[$];
    outcome_t expected_outcomes[$];

    int unsigned requests_queued = 0;
    int unsigned requests_taken  = 0;
    int unsigned random_count    = 0;
    int unsigned mismatches      = 0;

    // idle control: percent chance per cycle to start a burst, and burst countdowns
    int unsigned send_gap_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned send_idle     = 0;
    int unsigned recv_idle     = 0;

    // handshake seen at the last rising edge, read by the driver at the falling edge
    logic req_fired = 1'b0;

    // predicted buffer state, mirrors the block after reset
    logic [RECORD_W-1:0] records [DEPTH];
    logic [5:0]          wr_ptr   = '0;
    logic [5:0]          cm_start = '0;
    logic [6:0]          cm_len   = '0;
    logic [5:0]          sh_ptr   = '0;
    logic [6:0]          sh_len   = '0;
    logic                is_full  = 1'b0;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // slot after p, wrapping at the buffer depth
    function automatic logic [5:0] next_slot(logic [5:0] p);
        return (p == DEPTH - 1) ? 6'd0 : p + 6'd1;
    endfunction

    // make the shadow side the committed side; a no-op when the pointers
    // already agree and the buffer is not full
    function automatic void commit_shadow();
        if (cm_start != sh_ptr || is_full)
        begin
            cm_start = sh_ptr;
            cm_len   = sh_len;
            is_full  = 1'b0;
        end
    endfunction

    // apply one request to the predicted state and return its outcome
    function automatic outcome_t apply_request(request_t r);
        outcome_t o;
        o.accepted  = 1'b0;
        o.read_data = '0;
        case (r.req_type)
            REQ_PUSH:
            begin
                // refused outright while the full flag stands
                if (!is_full)
                begin
                    if (next_slot(wr_ptr) == cm_start)
                        is_full = 1'b1;
                    records[wr_ptr] = r.push_data;
                    wr_ptr = next_slot(wr_ptr);
                    if (cm_len < DEPTH)
                        cm_len++;
                    if (sh_len < DEPTH)
                        sh_len++;
                    o.accepted = 1'b1;
                end
            end
            REQ_GET:
            begin
                // a get on an empty shadow side changes nothing, commit flag or not
                if (sh_len != 0)
                begin
                    o.read_data = records[sh_ptr];
                    sh_ptr = next_slot(sh_ptr);
                    sh_len--;
                    if (r.commit_after_read)
                        commit_shadow();
                    o.accepted = 1'b1;
                end
            end
            REQ_COMMIT:
            begin
                commit_shadow();
                o.accepted = 1'b1;
            end
            REQ_ROLLBACK:
            begin
                sh_ptr = cm_start;
                sh_len = cm_len;
                o.accepted = 1'b1;
            end
            REQ_CLEAR:
            begin
                wr_ptr   = '0;
                cm_start = '0;
                cm_len   = '0;
                sh_ptr   = '0;
                sh_len   = '0;
                is_full  = 1'b0;
                o.accepted = 1'b1;
            end
            default:
            begin
                // unknown codes are answered but refused, state untouched
            end
        endcase
        o.pending_count = sh_len;
        o.full_flag     = is_full;
        return o;
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // generous bound: about 800 items at the longest idle plus the longest stall burst each
    initial
    begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // request driver: changes inputs at the falling edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        request_t r;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (req_ch.valid && !req_fired)
        begin
            // item still on offer, hold it
        end
        else if (send_idle > 0)
        begin
            send_idle--;
            req_ch.valid <= 1'b0;
        end
        else if (request_queue.size() == 0)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct)
        begin
            // start an idle burst, this one included
            send_idle = $urandom_range(18, 0);
            req_ch.valid <= 1'b0;
        end
        else
        begin
            r = request_queue.pop_front();
            req_ch.valid             <= 1'b1;
            req_ch.req_type          <= r.req_type;
            req_ch.push_data         <= r.push_data;
            req_ch.commit_after_read <= r.commit_after_read;
        end
    end

    // result side back-pressure, same burst scheme as the sender
    always @(negedge clk)
    begin
        if (recv_idle > 0)
        begin
            recv_idle--;
            res_ch.ready <= 1'b0;
        end
        else if (recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct)
        begin
            recv_idle = $urandom_range(18, 0);
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: samples both channels at the rising edge
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        request_t r;
        outcome_t want;
        if (rst_n)
        begin
            req_fired = req_ch.valid && req_ch.ready;
            if (req_fired)
            begin
                r.req_type          = req_ch.req_type;
                r.push_data         = req_ch.push_data;
                r.commit_after_read = req_ch.commit_after_read;
                expected_outcomes.push_back(apply_request(r));
                requests_taken++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("result item with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    check_field("accepted", DATA_W'(want.accepted),
                                DATA_W'(res_ch.accepted));
                    check_field("read_data", want.read_data, res_ch.read_data);
                    check_field("pending_count", DATA_W'(want.pending_count),
                                DATA_W'(res_ch.pending_count));
                    check_field("full_flag", DATA_W'(want.full_flag),
                                DATA_W'(res_ch.full_flag));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic queue_request(logic [2:0] code, logic [DATA_W-1:0] data, logic car);
        request_t r;
        r.req_type          = code;
        r.push_data         = data;
        r.commit_after_read = car;
        request_queue.push_back(r);
        requests_queued++;
        if (code <= REQ_CLEAR)
            random_count++;
    endtask

    // block until every queued item is taken and every result is back
    task automatic wait_drained();
        while (!(requests_taken == requests_queued && expected_outcomes.size() == 0))
            @(negedge clk);
    endtask

    // random request for the free mix, unknown codes included now and then
    task automatic queue_mixed();
        int unsigned pick;
        pick = $urandom_range(99, 0);
        if (pick < 35)
            queue_request(REQ_PUSH, $urandom, 1'($urandom_range(1, 0)));
        else if (pick < 65)
            queue_request(REQ_GET, $urandom, 1'($urandom_range(1, 0)));
        else if (pick < 77)
            queue_request(REQ_COMMIT, $urandom, 1'($urandom_range(1, 0)));
        else if (pick < 89)
            queue_request(REQ_ROLLBACK, $urandom, 1'($urandom_range(1, 0)));
        else if (pick < 92)
            queue_request(REQ_CLEAR, $urandom, 1'($urandom_range(1, 0)));
        else
            queue_request(3'(REQ_CLEAR + $urandom_range(3, 1)), $urandom,
                          1'($urandom_range(1, 0)));
    endtask

    initial
    begin
        int unsigned kind;
        int unsigned n;
        int unsigned pcts [3];

        pcts = '{0, 5, 25};

        // every input known from time zero
        rst_n                    = 1'b0;
        req_ch.valid             = 1'b0;
        req_ch.req_type          = REQ_PUSH;
        req_ch.push_data         = '0;
        req_ch.commit_after_read = 1'b0;
        res_ch.ready             = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part ----
        send_gap_pct   = 5;
        recv_stall_pct = 5;
        // failed get asking to commit, then commit with equal pointers while empty
        queue_request(REQ_GET, '0, 1'b1);
        queue_request(REQ_COMMIT, '0, 1'b0);
        // extremes of the record
        queue_request(REQ_PUSH, 32'h0000_0000, 1'b0);
        queue_request(REQ_PUSH, 32'hFFFF_FFFF, 1'b1);
        queue_request(REQ_PUSH, 32'h5A5A_A5A5, 1'b0);
        // speculative read, then roll it back
        queue_request(REQ_GET, '0, 1'b0);
        queue_request(REQ_ROLLBACK, '0, 1'b0);
        // read twice, the second commits
        queue_request(REQ_GET, '1, 1'b0);
        queue_request(REQ_GET, '1, 1'b1);
        // commit with pointers already equal and not full: no change
        queue_request(REQ_COMMIT, '0, 1'b1);
        queue_request(REQ_GET, '0, 1'b0);
        queue_request(REQ_ROLLBACK, '1, 1'b1);
        queue_request(REQ_PUSH, 32'h1234_5678, 1'b0);
        // unknown request codes
        queue_request(3'(REQ_CLEAR + 1), 32'hDEAD_BEEF, 1'b1);
        queue_request(3'(REQ_CLEAR + 2), '1, 1'b0);
        queue_request(3'(REQ_CLEAR + 3), '0, 1'b1);
        queue_request(REQ_GET, '0, 1'b1);
        queue_request(REQ_GET, '0, 1'b1);
        queue_request(REQ_GET, '0, 1'b0);
        queue_request(REQ_CLEAR, '1, 1'b1);
        queue_request(REQ_GET, '0, 1'b0);
        queue_request(REQ_PUSH, 32'hFFFF_FFFF, 1'b0);
        queue_request(REQ_GET, '0, 1'b1);

        // hold the sender until the block has answered everything
        wait_drained();

        // ---- random part: mostly coherent sequences ----
        while (random_count < RANDOM_ITEMS)
        begin
            if (random_count >= QUIET_FROM)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            else
            begin
                send_gap_pct   = pcts[$urandom_range(2, 0)];
                recv_stall_pct = pcts[$urandom_range(2, 0)];
            end

            kind = $urandom_range(99, 0);
            if (kind < 15)
            begin
                // fill toward or past full: pushes beyond capacity must be refused
                n = $urandom_range(70, 60);
                repeat (n) queue_request(REQ_PUSH, $urandom, 1'($urandom_range(1, 0)));
                if ($urandom_range(1, 0))
                    queue_request(REQ_COMMIT, $urandom, 1'b0);
            end
            else if (kind < 30)
            begin
                // drain, committing at random
                n = $urandom_range(70, 5);
                repeat (n) queue_request(REQ_GET, $urandom, 1'($urandom_range(1, 0)));
            end
            else if (kind < 55)
            begin
                // read transaction closed by commit or roll back
                n = $urandom_range(12, 1);
                repeat (n) queue_request(REQ_GET, $urandom, 1'b0);
                if ($urandom_range(1, 0))
                    queue_request(REQ_COMMIT, $urandom, 1'($urandom_range(1, 0)));
                else
                    queue_request(REQ_ROLLBACK, $urandom, 1'($urandom_range(1, 0)));
                n = $urandom_range(6, 0);
                repeat (n) queue_request(REQ_PUSH, $urandom, 1'($urandom_range(1, 0)));
            end
            else if (kind < 85)
            begin
                n = $urandom_range(30, 10);
                repeat (n) queue_mixed();
            end
            else if (kind < 90)
            begin
                queue_request(REQ_CLEAR, $urandom, 1'($urandom_range(1, 0)));
                n = $urandom_range(8, 1);
                repeat (n) queue_request(REQ_PUSH, $urandom, 1'($urandom_range(1, 0)));
            end
            else
            begin
                // noise: any code, unknown ones included
                n = $urandom_range(8, 3);
                repeat (n) queue_request(3'($urandom_range(7, 0)), $urandom,
                                         1'($urandom_range(1, 0)));
            end

            // keep the queue short so idle settings track the sequence
            while (request_queue.size() > 2)
                @(negedge clk);
        end

        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
